@@ design/sv39ptw_pkg.sv @@
package sv39ptw_pkg;

    localparam int LEVELS     = 3;
    localparam int LEVEL_W    = 2;
    localparam int PAGE_SHIFT = 12;
    localparam int VPN_W      = 9;
    localparam int VA_BITS    = PAGE_SHIFT + VPN_W * LEVELS;
    localparam int PPN_W      = 44;
    localparam int ADDR_W     = 64;
    localparam int DATA_W     = 64;
    localparam int PADDR_W    = 4;

    // func codes
    localparam logic FUNC_REQUEST  = 1'b0;
    localparam logic FUNC_RESPONSE = 1'b1;

    // access kinds, also the fault codes
    localparam logic [1:0] ACC_FETCH = 2'd0;
    localparam logic [1:0] ACC_LOAD  = 2'd1;
    localparam logic [1:0] ACC_STORE = 2'd2;

    // register index, taken from paddr[3]
    localparam logic CFG_PAGING_ENABLE = 1'b0;
    localparam logic CFG_ROOT_PPN      = 1'b1;

    typedef enum logic [1:0] {
        RES_READ  = 2'd0,
        RES_DONE  = 2'd1,
        RES_FAULT = 2'd2
    } result_kind_t;

    typedef struct packed {
        result_kind_t       kind;
        logic [ADDR_W-1:0]  addr;
        logic [1:0]         code;
    } result_t;

endpackage

@@ design/sv39_page_table_walker.sv @@
// sv39 page table walker
//
// input channel (in_valid / in_stall): one beat is either a translate request
// (func = 0: virtual_address, access_kind) or a page table entry response
// (func = 1: pte_data, bus_error). output channel (out_valid / out_stall):
// one beat is an entry read request, a finished translation or a page fault.
// the user sends every entry read request to memory and returns its data as a
// response beat; requests seen during a walk and responses seen while idle are
// dropped without a result.
//
// every input beat is decided in the cycle it is accepted and its result is
// registered in the output register, or in the skid register behind it while
// the output register holds a stalled beat. the block takes one beat per cycle
// while in_stall is low. a skid register holds one more result; in_stall rises
// only while both are full, i.e. after the receiver stalled with a beat waiting.
//
// reset clears both config registers (paging off, root ppn zero), ends any
// walk and empties the output and skid registers.
// config: apb, register 0 at 0x0 (paging_enable), register 1 at 0x8 (root ppn)
module sv39_page_table_walker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            func,
    input  logic [63:0]                     virtual_address,
    input  logic [1:0]                      access_kind,
    input  logic [63:0]                     pte_data,
    input  logic                            bus_error,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      result_kind,
    output logic [63:0]                     address_out,
    output logic [1:0]                      fault_code,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sv39ptw_pkg::PADDR_W-1:0] paddr,
    input  logic [sv39ptw_pkg::DATA_W-1:0]  pwdata,
    output logic [sv39ptw_pkg::DATA_W-1:0]  prdata,
    output logic                            pready
);
    import sv39ptw_pkg::*;

    // config registers
    logic              paging_en_reg;
    logic [PPN_W-1:0]  root_ppn_reg;
    logic              cfg_wr;

    // walk state
    logic               busy_reg, busy_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [VA_BITS-1:0] vaddr_reg, vaddr_next;
    logic [1:0]         access_reg, access_next;

    // output register and skid register
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_reg, skid_next;

    logic    accept;
    logic    out_fire;
    logic    res_valid;
    result_t res;

    logic [63:0]      pte;
    logic             pte_v, pte_r, pte_w, pte_x;
    logic [PPN_W-1:0] pte_ppn;
    logic [1:0]       fault_kind;

    // entry address: table base plus vpn of this level times eight
    function automatic logic [ADDR_W-1:0] entry_addr(
        input logic [PPN_W-1:0]   ppn,
        input logic [VA_BITS-1:0] va,
        input logic [LEVEL_W-1:0] lvl
    );
        logic [VA_BITS+VPN_W-1:0] ext;
        logic [VPN_W-1:0]         vpn;
        ext = {{VPN_W{1'b0}}, va};
        vpn = ext[PAGE_SHIFT + VPN_W * lvl +: VPN_W];
        return ADDR_W'({ppn, {PAGE_SHIFT{1'b0}}}) + ADDR_W'({vpn, 3'b000});
    endfunction

    // leaf address: superpages keep the lower page numbers of the va
    function automatic logic [ADDR_W-1:0] leaf_addr(
        input logic [PPN_W-1:0]   ppn,
        input logic [VA_BITS-1:0] va,
        input logic [LEVEL_W-1:0] lvl
    );
        logic [5:0]        keep;
        logic [ADDR_W-1:0] low;
        keep = 6'(PAGE_SHIFT + VPN_W * lvl);
        low  = ~({ADDR_W{1'b1}} << keep);
        return (ADDR_W'({ppn, {PAGE_SHIFT{1'b0}}}) & ~low) | (ADDR_W'(va) & low);
    endfunction

    // apb config port, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paging_en_reg <= 1'b0;
            root_ppn_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3])
                CFG_PAGING_ENABLE: paging_en_reg <= pwdata[0];
                CFG_ROOT_PPN:      root_ppn_reg  <= pwdata[PPN_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3])
            CFG_PAGING_ENABLE: prdata = DATA_W'(paging_en_reg);
            CFG_ROOT_PPN:      prdata = DATA_W'(root_ppn_reg);
            default:           prdata = '0;
        endcase
    end

    // handshakes: stall only while the skid register holds a beat
    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;

    // entry decode, a bus error reads as an all-zero entry
    assign pte     = bus_error ? 64'd0 : pte_data;
    assign pte_v   = pte[0];
    assign pte_r   = pte[1];
    assign pte_w   = pte[2];
    assign pte_x   = pte[3];
    assign pte_ppn = pte[10 +: PPN_W];

    // access kind three faults as a store
    assign fault_kind = (access_reg > ACC_STORE) ? ACC_STORE : access_reg;

    // walk step for the accepted beat
    always_comb
    begin
        busy_next     = busy_reg;
        level_next    = level_reg;
        vaddr_next    = vaddr_reg;
        access_next   = access_reg;
        res_valid     = 1'b0;
        res           = '{kind: RES_READ, addr: '0, code: ACC_FETCH};

        if (accept)
        begin
            if (func == FUNC_REQUEST)
            begin
                if (!busy_reg)
                begin
                    res_valid = 1'b1;
                    if (!paging_en_reg)
                    begin
                        // pass through
                        res.kind = RES_DONE;
                        res.addr = virtual_address;
                    end
                    else
                    begin
                        busy_next     = 1'b1;
                        level_next    = LEVEL_W'(LEVELS - 1);
                        vaddr_next    = virtual_address[VA_BITS-1:0];
                        access_next   = access_kind;
                        res.kind      = RES_READ;
                        res.addr      = entry_addr(root_ppn_reg,
                                                   virtual_address[VA_BITS-1:0],
                                                   LEVEL_W'(LEVELS - 1));
                    end
                end
            end
            else if (busy_reg)
            begin
                res_valid = 1'b1;
                if (!pte_v || (!pte_r && pte_w))
                begin
                    // invalid entry
                    busy_next = 1'b0;
                    res.kind  = RES_FAULT;
                    res.code  = fault_kind;
                end
                else if (pte_r || pte_x)
                begin
                    busy_next = 1'b0;
                    res.kind  = RES_DONE;
                    res.addr  = leaf_addr(pte_ppn, vaddr_reg, level_reg);
                end
                else if (level_reg == '0)
                begin
                    // pointer with no level left
                    busy_next = 1'b0;
                    res.kind  = RES_FAULT;
                    res.code  = fault_kind;
                end
                else
                begin
                    level_next    = level_reg - 1'b1;
                    res.kind      = RES_READ;
                    res.addr      = entry_addr(pte_ppn, vaddr_reg, level_reg - 1'b1);
                end
            end
        end
    end

    // output register with skid behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || out_fire)
        begin
            out_valid_next = res_valid;
            out_next       = res;
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            level_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            level_reg      <= level_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vaddr_reg    <= vaddr_next;
        access_reg   <= access_next;
        out_reg      <= out_next;
        skid_reg     <= skid_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_reg.kind;
    assign address_out = out_reg.addr;
    assign fault_code  = out_reg.code;

endmodule

@@ design/sv39ptw_checker.sv @@
module sv39ptw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  result_kind,
    input logic [63:0] address_out,
    input logic [1:0]  fault_code
);
    import sv39ptw_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(address_out)
            && $stable(result_kind) && $stable(fault_code))
        else $error("stalled result beat changed");

    // input stalls only with the output register full
    a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // an empty output register cannot lead to a stall next cycle
    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |=> !in_stall)
        else $error("stall after empty output");

    a_code_only_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != RES_FAULT |-> fault_code == ACC_FETCH)
        else $error("fault code set on a non-fault beat");

    a_fault_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == RES_FAULT |-> address_out == 64'd0)
        else $error("fault beat carries an address");

endmodule

bind sv39_page_table_walker sv39ptw_checker u_sv39ptw_checker (.*);

@@ dv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sv39ptw_pkg::*;

    // shapes of entry the random memory side returns
    typedef enum int {
        PTE_POINTER,
        PTE_LEAF,
        PTE_INVALID,
        PTE_WRITE_ONLY,
        PTE_NOISE
    } pte_shape_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                func;
    logic [63:0]         virtual_address;
    logic [1:0]          access_kind;
    logic [63:0]         pte_data;
    logic                bus_error;
    logic                out_valid;
    logic                out_stall;
    logic [1:0]          result_kind;
    logic [63:0]         address_out;
    logic [1:0]          fault_code;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    sv39_page_table_walker dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .virtual_address (virtual_address),
        .access_kind     (access_kind),
        .pte_data        (pte_data),
        .bus_error       (bus_error),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_kind     (result_kind),
        .address_out     (address_out),
        .fault_code      (fault_code),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // shadow copy of the config registers
    logic                paging_on = 1'b0;
    logic [PPN_W-1:0]    root_ppn  = '0;

    // shadow copy of the walk state
    logic                walk_active = 1'b0;
    logic [LEVEL_W-1:0]  walk_lvl    = '0;
    logic [VA_BITS-1:0]  walk_va     = '0;
    logic [1:0]          walk_acc    = '0;
    logic [55:0]         walk_base   = '0;

    // results still owed by the block, oldest first
    result_t             awaited_results[$];

    int                  err_count       = 0;
    int                  beats_sent      = 0;
    int                  settings_written = 0;
    int                  seen_reads      = 0;
    int                  seen_done       = 0;
    int                  seen_faults     = 0;

    // burst modes: while set a side never idles
    bit                  in_quiet  = 1'b0;
    bit                  out_quiet = 1'b0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit, far above the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // walk predictor
    // ---------------------------------------------------------------

    // address of the entry for the current level in the current table
    function automatic logic [63:0] entry_address();
        logic [VPN_W-1:0] vpn;
        vpn = VPN_W'(walk_va >> (PAGE_SHIFT + VPN_W * walk_lvl));
        return 64'(walk_base) + {vpn, 3'b000};
    endfunction

    // walk ends in a page fault coded by the latched access kind
    function automatic result_t walk_fault();
        result_t res;
        walk_active = 1'b0;
        res.kind = RES_FAULT;
        res.addr = '0;
        // kind three reports as a store
        res.code = (walk_acc > ACC_STORE) ? ACC_STORE : walk_acc;
        return res;
    endfunction

    // advance the shadow walk by one accepted beat and queue its result
    function automatic void predict_walk_beat(logic f, logic [63:0] va, logic [1:0] acc,
                                              logic [63:0] pte, logic berr);
        logic [63:0]      entry;
        logic [PPN_W-1:0] ppn;
        logic [63:0]      low_mask;
        logic [63:0]      va_ext;
        result_t          res;
        // a failed read counts as an all-zero entry
        entry    = berr ? 64'd0 : pte;
        ppn      = entry[10 +: PPN_W];
        res.kind = RES_READ;
        res.addr = '0;
        res.code = ACC_FETCH;
        if (f == FUNC_REQUEST)
        begin
            // requests during a walk are dropped
            if (walk_active)
                return;
            if (!paging_on)
            begin
                res.kind = RES_DONE;
                res.addr = va;
            end
            else
            begin
                walk_active = 1'b1;
                walk_lvl    = LEVEL_W'(LEVELS - 1);
                walk_va     = va[VA_BITS-1:0];
                walk_acc    = acc;
                walk_base   = {root_ppn, 12'h000};
                res.addr    = entry_address();
            end
        end
        else
        begin
            // responses while idle are dropped
            if (!walk_active)
                return;
            if (!entry[0] || (!entry[1] && entry[2]))
                res = walk_fault();
            else if (entry[1] || entry[3])
            begin
                // leaf: superpages keep the lower vpn fields of the address
                low_mask    = (64'd1 << (PAGE_SHIFT + VPN_W * walk_lvl)) - 64'd1;
                va_ext      = 64'(walk_va);
                res.kind    = RES_DONE;
                res.addr    = (64'({ppn, 12'h000}) & ~low_mask) | (va_ext & low_mask);
                walk_active = 1'b0;
            end
            else if (walk_lvl == 0)
                res = walk_fault();
            else
            begin
                walk_lvl  = walk_lvl - 1'b1;
                walk_base = {ppn, 12'h000};
                res.addr  = entry_address();
            end
        end
        awaited_results.push_back(res);
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // one input beat; returns once it has been taken
    task automatic send_beat(logic f, logic [63:0] va, logic [1:0] acc,
                             logic [63:0] pte, logic berr);
        int gap;
        if ($urandom_range(0, 29) == 0)
            in_quiet = !in_quiet;
        gap = in_quiet ? 0 : $urandom_range(0, 12);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid        <= 1'b1;
        func            <= f;
        virtual_address <= va;
        access_kind     <= acc;
        pte_data        <= pte;
        bus_error       <= berr;
        do
            @(posedge clk);
        while (in_stall);
        predict_walk_beat(f, va, acc, pte, berr);
        beats_sent++;
    endtask

    task automatic send_request(logic [63:0] va, logic [1:0] acc);
        send_beat(FUNC_REQUEST, va, acc, {$urandom, $urandom}, 1'($urandom));
    endtask

    task automatic send_response(logic [63:0] pte, logic berr);
        send_beat(FUNC_RESPONSE, {$urandom, $urandom}, 2'($urandom), pte, berr);
    endtask

    // apb write: setup then access phase
    task automatic apb_write(logic idx, logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == CFG_PAGING_ENABLE)
            paging_on = value[0];
        else
            root_ppn = value[PPN_W-1:0];
        settings_written++;
    endtask

    // stop sending, wait for every owed result plus the block's latency
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // random entry of a given shape, all other bits random
    function automatic logic [63:0] make_pte(pte_shape_t shape);
        logic [63:0] e;
        e = {$urandom, $urandom};
        case (shape)
            PTE_POINTER:    e[3:0] = 4'b0001;
            PTE_LEAF:
            begin
                e[0] = 1'b1;
                if ($urandom_range(0, 2) != 0)
                    e[1] = 1'b1;
                else
                    e[3:1] = 3'b100;
            end
            PTE_INVALID:    e[0] = 1'b0;
            PTE_WRITE_ONLY: e[2:0] = 3'b101;
            default:        ;
        endcase
        return e;
    endfunction

    // ---------------------------------------------------------------
    // receiver: random stalls, then check every beat
    // ---------------------------------------------------------------

    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                out_quiet = !out_quiet;
            hold = out_quiet ? 0 : $urandom_range(0, 12);
            repeat (hold)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result beat: kind %0d addr %0h code %0d",
                       result_kind, address_out, fault_code);
                err_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (result_kind !== want.kind)
                begin
                    $error("result_kind: expected %0d, got %0d", want.kind, result_kind);
                    err_count++;
                end
                if (address_out !== want.addr)
                begin
                    $error("address_out: expected %0h, got %0h", want.addr, address_out);
                    err_count++;
                end
                if (fault_code !== want.code)
                begin
                    $error("fault_code: expected %0d, got %0d", want.code, fault_code);
                    err_count++;
                end
                case (want.kind)
                    RES_READ:  seen_reads++;
                    RES_DONE:  seen_done++;
                    default:   seen_faults++;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // paging off after reset: addresses come back untouched, strays dropped
    task automatic test_passthrough();
        send_request(64'h0, ACC_FETCH);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, ACC_LOAD);
        send_request(64'hAAAA_AAAA_AAAA_AAAA, ACC_STORE);
        send_request(64'h5555_5555_5555_5555, 2'd3);
        send_response(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        drain_results();
    endtask

    // one walk per way of ending it
    task automatic test_walk_shapes();
        apb_write(CFG_PAGING_ENABLE, 64'd1);
        apb_write(CFG_ROOT_PPN, 64'h0000_0FFF_FFFF_FFFF);
        // full three-level walk: all-ones root and first pointer, zero second pointer, all-ones leaf
        send_request(64'hFFFF_FFFF_FFFF_FFFF, ACC_LOAD);
        send_response(64'hFFFF_FFFF_FFFF_FC01, 1'b0);
        send_response(64'h0000_0000_0000_0001, 1'b0);
        send_response(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        // gigapage leaf at the top level
        send_request(64'h0, ACC_FETCH);
        send_response(64'h0000_0000_2000_00CB, 1'b0);
        // megapage leaf one level down
        send_request({$urandom, $urandom}, ACC_STORE);
        send_response(64'h0000_0000_0012_3401, 1'b0);
        send_response(64'h0000_0000_0ABC_D807, 1'b0);
        // invalid entry, access kind three faults as a store
        send_request({$urandom, $urandom}, 2'd3);
        send_response(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
        // write without read
        send_request({$urandom, $urandom}, ACC_LOAD);
        send_response(64'h0000_0000_0000_0401, 1'b0);
        send_response(64'h0000_0000_0000_0005, 1'b0);
        // bus error hides an otherwise good leaf
        send_request({$urandom, $urandom}, ACC_FETCH);
        send_response(64'h0000_0000_0000_000F, 1'b1);
        // pointer at the last level, with a request dropped mid-walk
        send_request({$urandom, $urandom}, ACC_STORE);
        send_response(64'h0000_0000_0000_0801, 1'b0);
        send_request({$urandom, $urandom}, ACC_FETCH);
        send_response(64'h0000_0000_0000_0C01, 1'b0);
        send_response(64'h0000_0000_0000_1001, 1'b0);
        drain_results();
    endtask

    // config changes while a walk is open: the walk carries on through its entries
    task automatic test_config_during_walk();
        apb_write(CFG_ROOT_PPN, 64'h0);
        send_request({$urandom, $urandom}, ACC_LOAD);
        drain_results();
        apb_write(CFG_PAGING_ENABLE, 64'd0);
        send_response(64'h0000_0000_0034_5601, 1'b0);
        drain_results();
        apb_write(CFG_ROOT_PPN, 64'(44'($urandom) << 12 | 44'($urandom)));
        send_response(64'h0000_0000_0001_2803, 1'b0);
        // walk over, paging off now passes through
        send_request({$urandom, $urandom}, ACC_STORE);
        drain_results();
    endtask

    // mostly complete walks with random entries, some strays and drops
    task automatic test_random_traffic();
        logic [63:0] va;
        logic [63:0] root;
        pte_shape_t  shape;
        int          pick;
        int          phase_end;
        for (int p = 0; p < 8; p++)
        begin
            drain_results();
            case (p)
                0:       root = 64'h0000_0FFF_FFFF_FFFF;
                1:       root = 64'h0;
                default: root = 64'({$urandom, $urandom} & 64'h0000_0FFF_FFFF_FFFF);
            endcase
            // one phase with paging off
            apb_write(CFG_PAGING_ENABLE, (p == 6) ? 64'd0 : 64'd1);
            apb_write(CFG_ROOT_PPN, root);
            phase_end = beats_sent + 240;
            while (beats_sent < phase_end)
            begin
                if (!walk_active)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_response({$urandom, $urandom}, 1'($urandom));
                    else
                    begin
                        va = {$urandom, $urandom};
                        if ($urandom_range(0, 3) == 0)
                            va[63:VA_BITS] = '0;
                        send_request(va, 2'($urandom_range(0, 3)));
                    end
                end
                else if ($urandom_range(0, 14) == 0)
                    send_request({$urandom, $urandom}, 2'($urandom_range(0, 3)));
                else
                begin
                    // upper levels mostly descend, the last level mostly ends in a leaf
                    pick = $urandom_range(0, 99);
                    if (walk_lvl != 0)
                        shape = (pick < 55) ? PTE_POINTER : (pick < 80) ? PTE_LEAF :
                                (pick < 88) ? PTE_INVALID : (pick < 94) ? PTE_WRITE_ONLY :
                                PTE_NOISE;
                    else
                        shape = (pick < 65) ? PTE_LEAF : (pick < 78) ? PTE_POINTER :
                                (pick < 86) ? PTE_INVALID : (pick < 93) ? PTE_WRITE_ONLY :
                                PTE_NOISE;
                    send_response(make_pte(shape), ($urandom_range(0, 19) == 0));
                end
            end
        end
        drain_results();
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        func            = FUNC_REQUEST;
        virtual_address = '0;
        access_kind     = ACC_FETCH;
        pte_data        = '0;
        bus_error       = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_passthrough();
        test_walk_shapes();
        test_config_during_walk();
        test_random_traffic();

        $display("sent %0d input beats across %0d register writes", beats_sent,
                 settings_written);
        $display("checked %0d entry reads, %0d translations, %0d page faults",
                 seen_reads, seen_done, seen_faults);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
